[sv/gar_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gar_pkg
// Shared codes, constants and the command type passed from the front end to
// the back end of the graphics aperture register window.
// ----------------------------------------------------------------------------
package gar_pkg;

  // Bus operation codes
  localparam logic [1:0] OP_IO_RD  = 2'd0;
  localparam logic [1:0] OP_IO_WR  = 2'd1;
  localparam logic [1:0] OP_MEM_RD = 2'd2;
  localparam logic [1:0] OP_MEM_WR = 2'd3;

  // Access size codes (anything above word is a dword)
  localparam logic [1:0] SZ_BYTE      = 2'd0;
  localparam logic [1:0] SZ_WORD      = 2'd1;
  localparam logic [1:0] SZ_DWORD     = 2'd2;
  localparam logic [1:0] SZ_DWORD_ALT = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_WINDOW = 2'd1;
  localparam logic [1:0] ST_MEMORY = 2'd2;
  localparam logic [1:0] ST_PASS   = 2'd3;

  localparam int ADDR_W   = 24;
  localparam int DATA_W   = 32;
  localparam int REG_NUM  = 16;
  localparam int REG_IDX_W = 4;
  localparam int MA_W     = 22;   // six bank bits above a 16-bit window offset

  localparam logic [ADDR_W-1:0] WINDOW_RESET  = 24'h0A0000;
  localparam logic [ADDR_W:0]   WINDOW_SPAN   = 25'h0010000;
  localparam logic [ADDR_W-1:0] REG_PORT_BASE = 24'h002100;
  localparam logic [ADDR_W-1:0] ID_PORT_LO    = 24'h000100;
  localparam logic [ADDR_W-1:0] ID_PORT_HI    = 24'h000101;
  localparam logic [7:0]        ID_BYTE_LO    = 8'hFE;
  localparam logic [7:0]        ID_BYTE_HI    = 8'hE8;
  localparam logic [DATA_W-1:0] REJECT_VALUE  = 32'h0000_00FF;
  localparam logic [2:0]        MODE_MASK     = 3'h7;
  localparam logic [2:0]        MODE_MIN      = 3'd4;
  localparam logic [5:0]        BANK_MASK     = 6'h3F;

  localparam logic [REG_IDX_W-1:0] REG_MODE     = 4'd0;
  localparam logic [REG_IDX_W-1:0] REG_APERTURE = 4'd1;
  localparam logic [REG_IDX_W-1:0] REG_BANK     = 4'd8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // One classified access. mem set means the back end must touch video
  // memory; otherwise rd and st already hold the finished result.
  typedef struct packed {
    logic              mem;
    logic              wr;
    logic [MA_W-1:0]   ma;
    logic [1:0]        nm1;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] rd;
    logic [1:0]        st;
  } gar_cmd_t;

endpackage
`default_nettype wire

[sv/gar_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gar_req_if
// Request channel: one bus access per transfer.
// ----------------------------------------------------------------------------
interface gar_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [23:0] address;
  logic [1:0]  access_size;
  logic [31:0] write_data;

  modport source (output valid, operation, address, access_size, write_data,
                  input ready);
  modport sink   (input valid, operation, address, access_size, write_data,
                  output ready);
endinterface
`default_nettype wire

[sv/gar_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gar_rsp_if
// Response channel: one result per bus access.
// ----------------------------------------------------------------------------
interface gar_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [1:0]  status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface
`default_nettype wire

[sv/gar_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gar_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module gar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/gar_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gar_front
// Accepts bus accesses, owns the I/O register bank and window base, and
// classifies each access into a finished result or a video memory command.
// ----------------------------------------------------------------------------
module gar_front #(
  parameter int VIDEO_MEM_BYTES = 1048576
) (
  input  wire logic             clk,
  input  wire logic             rst,
  gar_req_if.sink               req,
  output logic                  push_valid,
  input  wire logic             push_ready,
  output gar_pkg::gar_cmd_t     push_cmd
);
  import gar_pkg::*;

  localparam logic [MA_W:0] MEM_LIMIT = (MA_W+1)'(VIDEO_MEM_BYTES);

  logic [7:0]        regs [REG_NUM];
  logic [ADDR_W-1:0] window_base;

  logic              accept;
  logic              reg_port;
  logic [REG_IDX_W-1:0] idx;
  logic [1:0]        ap;
  logic [ADDR_W:0]   win_end;
  logic              claimed;
  logic [1:0]        nm1;
  logic [2:0]        nbytes;
  logic [15:0]       off;
  logic [16:0]       off_end;
  logic [MA_W-1:0]   ma;
  logic [MA_W:0]     ma_end;
  logic [5:0]        bank;

  assign accept     = req.valid && push_ready;
  assign req.ready  = push_ready;
  assign push_valid = req.valid;

  assign idx      = req.address[REG_IDX_W-1:0];
  assign reg_port = (req.address[ADDR_W-1:REG_IDX_W] == REG_PORT_BASE[ADDR_W-1:REG_IDX_W]);
  assign ap       = req.write_data[1:0];

  assign win_end = {1'b0, window_base} + WINDOW_SPAN;
  assign claimed = ((regs[REG_MODE][2:0] & MODE_MASK) >= MODE_MIN)
                   && (req.address >= window_base)
                   && ({1'b0, req.address} < win_end);

  always_comb begin
    case (req.access_size)
      SZ_BYTE: nm1 = 2'd0;
      SZ_WORD: nm1 = 2'd1;
      default: nm1 = 2'd3;
    endcase
  end

  assign nbytes  = {1'b0, nm1} + 3'd1;
  assign off     = 16'(req.address - window_base);
  assign off_end = {1'b0, off} + 17'(nbytes);
  assign bank    = regs[REG_BANK][5:0] & BANK_MASK;
  assign ma      = {bank, off};
  assign ma_end  = {1'b0, ma} + (MA_W+1)'(nbytes);

  always_comb begin
    push_cmd       = '0;
    push_cmd.st    = ST_PASS;
    push_cmd.wr    = req.operation[0];
    push_cmd.ma    = ma;
    push_cmd.nm1   = nm1;
    push_cmd.wdata = req.write_data;
    unique case (req.operation) inside
      OP_IO_RD: begin
        if (req.address == ID_PORT_LO) begin
          push_cmd.rd = 32'(ID_BYTE_LO);
          push_cmd.st = ST_DONE;
        end else if (req.address == ID_PORT_HI) begin
          push_cmd.rd = 32'(ID_BYTE_HI);
          push_cmd.st = ST_DONE;
        end else if (reg_port) begin
          push_cmd.rd = 32'(regs[idx]);
          push_cmd.st = ST_DONE;
        end
      end
      OP_IO_WR: begin
        if (reg_port) begin
          push_cmd.st = ST_DONE;
        end
      end
      OP_MEM_RD, OP_MEM_WR: begin
        if (claimed) begin
          if (off_end > 17'(WINDOW_SPAN)) begin
            push_cmd.st = ST_WINDOW;
          end else if (ma_end > MEM_LIMIT) begin
            push_cmd.st = ST_MEMORY;
          end else begin
            push_cmd.st  = ST_DONE;
            push_cmd.mem = 1'b1;
          end
          if (push_cmd.st != ST_DONE && req.operation == OP_MEM_RD) begin
            push_cmd.rd = REJECT_VALUE;
          end
        end
      end
      default: push_cmd.st = ST_PASS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_NUM; i++) begin
        regs[i] <= '0;
      end
      regs[REG_MODE]     <= 8'd1;
      regs[REG_APERTURE] <= 8'd1;
      window_base        <= WINDOW_RESET;
    end else if (accept && req.operation == OP_IO_WR && reg_port) begin
      regs[idx] <= req.write_data[7:0];
      // A nonzero aperture field moves the window in 64 KB steps from 0xA0000.
      if (idx == REG_APERTURE && ap != 2'd0) begin
        window_base <= WINDOW_RESET + {6'd0, 2'(ap - 2'd1), 16'd0};
      end
    end
  end
endmodule
`default_nettype wire

[sv/gar_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gar_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module gar_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire gar_pkg::gar_cmd_t push_cmd,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output gar_pkg::gar_cmd_t      pop_cmd
);
  import gar_pkg::*;

  gar_cmd_t               slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wptr;
  logic [QUEUE_PTR_W-1:0] rptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (count != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QUEUE_PTR_W'(QUEUE_DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == QUEUE_PTR_W'(QUEUE_DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

[sv/gar_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gar_back
// Carries out queued commands: walks the bytes of a video memory access one
// per cycle and holds each result in an output register until transferred.
// ----------------------------------------------------------------------------
module gar_back #(
  parameter int VIDEO_MEM_BYTES = 1048576
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire gar_pkg::gar_cmd_t cmd,
  gar_rsp_if.source              rsp
);
  import gar_pkg::*;

  localparam int AW = $clog2(VIDEO_MEM_BYTES);

  gar_cmd_t          cur;
  logic              busy;
  logic [1:0]        cnt;
  logic              rvalid;
  logic [1:0]        rlane;
  logic              rlast;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] merged;
  logic              out_valid;
  logic [DATA_W-1:0] out_rd;
  logic [1:0]        out_st;
  logic              out_fire;
  logic              take;
  logic [MA_W-1:0]   byte_addr;
  logic              ram_we;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic              last_issue;

  assign out_fire  = out_valid && rsp.ready;
  assign cmd_ready = !busy && !rvalid && (!out_valid || rsp.ready);
  assign take      = cmd_valid && cmd_ready;

  assign byte_addr  = cur.ma + MA_W'(cnt);
  assign ram_we     = busy && cur.wr;
  assign ram_wdata  = cur.wdata[8*cnt +: 8];
  assign last_issue = busy && (cnt == cur.nm1);

  gar_ram #(
    .WIDTH (8),
    .DEPTH (VIDEO_MEM_BYTES)
  ) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (byte_addr[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (byte_addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    merged = acc;
    merged[8*rlane +: 8] = ram_rdata;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= cmd;
    end
    if (take) begin
      acc <= '0;
    end else if (rvalid) begin
      acc <= merged;
    end
    rlane <= cnt;
    rlast <= last_issue;
    if (take && !cmd.mem) begin
      out_rd <= cmd.rd;
      out_st <= cmd.st;
    end else if (last_issue && cur.wr) begin
      out_rd <= '0;
      out_st <= ST_DONE;
    end else if (rvalid && rlast) begin
      out_rd <= merged;
      out_st <= ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      rvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rvalid <= busy && !cur.wr;
      if (take && cmd.mem) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (last_issue) begin
        busy <= 1'b0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
      end
      if ((take && !cmd.mem) || (last_issue && cur.wr) || (rvalid && rlast)) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_rd;
  assign rsp.status    = out_st;
endmodule
`default_nettype wire

[sv/graphics_aperture_register_window.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// graphics_aperture_register_window
// Bus access handler for a graphics adapter: I/O register bank, ID bytes and
// a 64 KB aperture into byte-addressed, little-endian video memory.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  req      in         operation, address, access_size, write_data
//  rsp      out        read_data, status (one result per request)
//
//  A request is classified and queued in the cycle it is transferred; I/O,
//  rejected and passed-on results are registered when the back end takes them.
//  A claimed access walks its bytes in order through the video memory; a read
//  also waits for the registered RAM data of its last byte before it finishes.
//  Reset sets registers 0 and 1 to one, the rest to zero, the window to 0xA0000.
//  A stalled response holds the back end; the two-entry queue then fills up.
// ----------------------------------------------------------------------------
module graphics_aperture_register_window #(
  parameter int VIDEO_MEM_BYTES = 1048576
) (
  input wire logic clk,
  input wire logic rst,
  gar_req_if.sink   req,
  gar_rsp_if.source rsp
);
  import gar_pkg::*;

  logic     push_valid;
  logic     push_ready;
  gar_cmd_t push_cmd;
  logic     pop_valid;
  logic     pop_ready;
  gar_cmd_t pop_cmd;

  gar_front #(
    .VIDEO_MEM_BYTES (VIDEO_MEM_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  gar_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  gar_back #(
    .VIDEO_MEM_BYTES (VIDEO_MEM_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .rsp       (rsp)
  );
endmodule
`default_nettype wire

[sv/gar_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gar_checker
// Port-level checks on the graphics aperture register window.
// ----------------------------------------------------------------------------
module gar_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [31:0] rsp_read_data,
  input wire logic [1:0]  rsp_status
);
  import gar_pkg::*;

  // Requests transferred whose result has not yet been transferred.
  logic [3:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(req_valid && req_ready) - 4'(rsp_valid && rsp_ready);
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_status))
    else $error("response changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 4'd0)
    else $error("response without an outstanding request");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 4'(QUEUE_DEPTH + 2))
    else $error("more requests in flight than the design can hold");

  a_pass_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_PASS |-> rsp_read_data == '0)
    else $error("passed-on access returned data");

  a_reject_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_WINDOW || rsp_status == ST_MEMORY)
      |-> rsp_read_data == '0 || rsp_read_data == REJECT_VALUE)
    else $error("rejected access returned unexpected data");
endmodule

bind graphics_aperture_register_window gar_checker u_gar_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_read_data (rsp.read_data),
  .rsp_status    (rsp.status)
);
`default_nettype wire

[sim/tb_graphics_aperture_register_window.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_graphics_aperture_register_window
// Drives bus accesses into the aperture register window and checks every
// reply against a shadow of the register bank, the window base and the
// written part of video memory. Directed tests cover the ID ports, the
// register range edges, aperture control, mode gating, access sizes and the
// window and memory limits; a random phase and a long reply stall follow.
// ----------------------------------------------------------------------------
module tb_graphics_aperture_register_window;
  import gar_pkg::*;

  localparam int unsigned VRAM_BYTES   = 1048576;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned LONG_HOLD    = 120;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam logic [ADDR_W-1:0] REG_PORT_LAST = REG_PORT_BASE + ADDR_W'(REG_NUM - 1);
  localparam logic [5:0] HOT_BANKS [3] = '{6'd0, 6'd1, 6'd15};

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [1:0]        status;
  } bus_reply_t;

  logic clk;
  logic rst;

  gar_req_if req_bus ();
  gar_rsp_if rsp_bus ();

  graphics_aperture_register_window #(
    .VIDEO_MEM_BYTES(VRAM_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  // Shadow state of the adapter
  logic [7:0]        reg_bank [REG_NUM];
  logic [ADDR_W-1:0] win_base;
  logic [7:0]        vram_shadow [int unsigned];

  bus_reply_t expected_replies [$];
  int unsigned mismatch_count = 0;

  bit steady_requests = 1'b0;
  bit steady_replies  = 1'b0;
  bit hold_replies    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_500_000;
    $display("graphics_aperture_register_window: mismatch");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Classifies a memory access against the current mode, window and bank.
  function automatic logic [1:0] map_access(input logic [ADDR_W-1:0] addr,
                                            input logic [1:0] size,
                                            output int unsigned ma,
                                            output int unsigned nbytes);
    int unsigned off;
    nbytes = (size == SZ_BYTE) ? 1 : (size == SZ_WORD) ? 2 : 4;
    ma = 0;
    if ((reg_bank[REG_MODE][2:0] & MODE_MASK) < MODE_MIN || addr < win_base ||
        addr >= win_base + WINDOW_SPAN)
      return ST_PASS;
    off = addr - win_base;
    if (off + nbytes > WINDOW_SPAN) return ST_WINDOW;
    ma = (reg_bank[REG_BANK] & BANK_MASK) * WINDOW_SPAN + off;
    if (ma + nbytes > VRAM_BYTES) return ST_MEMORY;
    return ST_DONE;
  endfunction

  function automatic bit touches_unwritten(input logic [ADDR_W-1:0] addr,
                                           input logic [1:0] size);
    int unsigned ma, nbytes;
    if (map_access(addr, size, ma, nbytes) != ST_DONE) return 1'b0;
    for (int unsigned i = 0; i < nbytes; i++)
      if (!vram_shadow.exists(ma + i)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bus_reply_t predict_access(input logic [1:0] op,
                                                input logic [ADDR_W-1:0] addr,
                                                input logic [1:0] size,
                                                input logic [DATA_W-1:0] data);
    bus_reply_t r;
    bit reg_hit;
    int unsigned ma, nbytes;
    r.read_data = '0;
    r.status = ST_PASS;
    reg_hit = addr >= REG_PORT_BASE && addr <= REG_PORT_LAST;
    case (op)
      OP_IO_RD: begin
        if (addr == ID_PORT_LO) begin
          r.read_data = DATA_W'(ID_BYTE_LO);
          r.status = ST_DONE;
        end else if (addr == ID_PORT_HI) begin
          r.read_data = DATA_W'(ID_BYTE_HI);
          r.status = ST_DONE;
        end else if (reg_hit) begin
          r.read_data = DATA_W'(reg_bank[addr[3:0]]);
          r.status = ST_DONE;
        end
      end
      OP_IO_WR: begin
        if (reg_hit) begin
          // A zero aperture field leaves the window where it is.
          if (addr[3:0] == REG_APERTURE && data[1:0] != 2'd0)
            win_base = ADDR_W'(WINDOW_RESET + (data[1:0] - 1) * WINDOW_SPAN);
          reg_bank[addr[3:0]] = data[7:0];
          r.status = ST_DONE;
        end
      end
      default: begin
        r.status = map_access(addr, size, ma, nbytes);
        if (r.status == ST_DONE) begin
          for (int unsigned i = 0; i < nbytes; i++) begin
            if (op == OP_MEM_RD) r.read_data[8*i +: 8] = vram_shadow[ma + i];
            else vram_shadow[ma + i] = data[8*i +: 8];
          end
        end else if (op == OP_MEM_RD && r.status != ST_PASS) begin
          r.read_data = REJECT_VALUE;
        end
      end
    endcase
    return r;
  endfunction

  // Called and returns at a falling edge; valid stays high between
  // back-to-back transfers.
  task automatic send_access(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [1:0] size, input logic [DATA_W-1:0] data);
    int unsigned gap;
    gap = (steady_requests || $urandom_range(0, 99) < 60) ? 0 : gap_length();
    // Never read video memory that has not been written; write it instead.
    if (op == OP_MEM_RD && touches_unwritten(addr, size)) op = OP_MEM_WR;
    if (gap != 0) begin
      req_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid = 1'b1;
    req_bus.operation = op;
    req_bus.address = addr;
    req_bus.access_size = size;
    req_bus.write_data = data;
    do @(posedge clk); while (!req_bus.ready);
    expected_replies.push_back(predict_access(op, addr, size, data));
    @(negedge clk);
  endtask

  initial begin : reply_pacing
    int unsigned stall_left;
    stall_left = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_replies) begin
        hold_replies = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left != 0) begin
        rsp_bus.ready = 1'b0;
        stall_left--;
      end else if (!steady_replies && $urandom_range(0, 99) < 20) begin
        rsp_bus.ready = 1'b0;
        stall_left = gap_length() - 1;
      end else begin
        rsp_bus.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : reply_check
    bus_reply_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_replies.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected reply, expected none, actual data %h status %0d",
                 $time, rsp_bus.read_data, rsp_bus.status);
      end else begin
        want = expected_replies.pop_front();
        if (rsp_bus.read_data !== want.read_data || rsp_bus.status !== want.status) begin
          mismatch_count++;
          $display("%0t: reply mismatch, expected data %h status %0d, actual data %h status %0d",
                   $time, want.read_data, want.status, rsp_bus.read_data, rsp_bus.status);
        end
      end
    end
  end

  task automatic test_id_ports();
    send_access(OP_IO_RD, ID_PORT_LO, SZ_BYTE, 32'h0);
    send_access(OP_IO_RD, ID_PORT_HI, SZ_BYTE, 32'h0);
    // The ID ports are read-only, so writes to them go elsewhere.
    send_access(OP_IO_WR, ID_PORT_HI, SZ_BYTE, 32'hFFFF_FFFF);
    send_access(OP_IO_RD, 24'h000000, SZ_BYTE, 32'h0);
    send_access(OP_IO_RD, REG_PORT_LAST + 24'd1, SZ_BYTE, 32'h0);
    send_access(OP_IO_RD, 24'hFFFFFF, SZ_BYTE, 32'h0);
  endtask

  task automatic test_register_bank();
    send_access(OP_IO_RD, REG_PORT_BASE, SZ_BYTE, 32'h0);
    send_access(OP_IO_WR, REG_PORT_LAST, SZ_BYTE, 32'hFFFF_FF5A);
    send_access(OP_IO_RD, REG_PORT_LAST, SZ_BYTE, 32'h0);
  endtask

  task automatic test_mode_gate();
    // Mode is one after reset, so the window is not yet claimed.
    send_access(OP_MEM_WR, WINDOW_RESET, SZ_BYTE, 32'h0000_0011);
    send_access(OP_IO_WR, REG_PORT_BASE + REG_MODE, SZ_BYTE, 32'h0000_00FC);
  endtask

  task automatic test_aperture_control();
    send_access(OP_IO_WR, REG_PORT_BASE + REG_APERTURE, SZ_BYTE, 32'hFFFF_FFFF);
    send_access(OP_MEM_WR, 24'h0C0000, SZ_DWORD, 32'h0);
    send_access(OP_IO_WR, REG_PORT_BASE + REG_APERTURE, SZ_BYTE, 32'h0000_005C);
    send_access(OP_IO_RD, REG_PORT_BASE + REG_APERTURE, SZ_BYTE, 32'h0);
    send_access(OP_IO_WR, REG_PORT_BASE + REG_APERTURE, SZ_BYTE, 32'h0000_0001);
  endtask

  task automatic test_memory_sizes();
    send_access(OP_MEM_WR, WINDOW_RESET, SZ_DWORD, 32'h89AB_CDEF);
    send_access(OP_MEM_RD, WINDOW_RESET + 24'd3, SZ_BYTE, 32'h0);
    send_access(OP_MEM_RD, WINDOW_RESET + 24'd2, SZ_WORD, 32'h0);
    // Size code three behaves as a dword.
    send_access(OP_MEM_RD, WINDOW_RESET, SZ_DWORD_ALT, 32'h0);
  endtask

  task automatic test_window_edges();
    send_access(OP_MEM_RD, WINDOW_RESET - 24'd1, SZ_BYTE, 32'h0);
    send_access(OP_MEM_WR, WINDOW_RESET + 24'h00FFFF, SZ_WORD, 32'h1234_5678);
    send_access(OP_MEM_RD, WINDOW_RESET + 24'h00FFFE, SZ_DWORD, 32'h0);
    send_access(OP_MEM_RD, ADDR_W'(WINDOW_RESET + WINDOW_SPAN), SZ_BYTE, 32'h0);
  endtask

  task automatic test_memory_limit();
    // Bank sixteen lies past the end of a 1 MB video memory.
    send_access(OP_IO_WR, REG_PORT_BASE + REG_BANK, SZ_BYTE, 32'h0000_00D0);
    send_access(OP_MEM_RD, WINDOW_RESET, SZ_BYTE, 32'h0);
    send_access(OP_IO_WR, REG_PORT_BASE + REG_BANK, SZ_BYTE, 32'h0000_000F);
    send_access(OP_MEM_WR, WINDOW_RESET + 24'h00FFFF, SZ_BYTE, 32'h0000_00A5);
    send_access(OP_MEM_RD, WINDOW_RESET + 24'h00FFFF, SZ_BYTE, 32'h0);
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    int unsigned off;
    logic [1:0] op;
    logic [ADDR_W-1:0] addr;
    logic [3:0] idx;
    logic [DATA_W-1:0] data;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        steady_requests = ($urandom_range(0, 3) == 0);
        steady_replies = ($urandom_range(0, 3) == 0);
      end
      data = $urandom;
      op = $urandom_range(0, 1) ? OP_MEM_RD : OP_MEM_WR;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        case ($urandom_range(0, 3))
          0: idx = REG_MODE;
          1: idx = REG_APERTURE;
          2: idx = REG_BANK;
          default: idx = 4'($urandom_range(0, REG_NUM - 1));
        endcase
        // Keep the window claimed and the bank inside memory most of the time.
        if (idx == REG_MODE && $urandom_range(0, 3) != 0) data[2:0] = 3'($urandom_range(4, 7));
        if (idx == REG_BANK && $urandom_range(0, 4) != 0)
          data[5:0] = HOT_BANKS[2'($urandom_range(0, 2))];
        send_access(OP_IO_WR, REG_PORT_BASE + ADDR_W'(idx), 2'($urandom_range(0, 3)), data);
      end else if (pick < 16) begin
        case ($urandom_range(0, 5)) inside
          0: addr = ID_PORT_LO;
          1: addr = ID_PORT_HI;
          2, 3: addr = REG_PORT_BASE + ADDR_W'($urandom_range(0, REG_NUM - 1));
          4: addr = $urandom_range(0, 1) ? REG_PORT_BASE - 24'd1 : REG_PORT_LAST + 24'd1;
          default: addr = ADDR_W'($urandom);
        endcase
        send_access(OP_IO_RD, addr, 2'($urandom_range(0, 3)), data);
      end else if (pick < 80) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) off = $urandom_range(0, 63);
        else if (pick < 9) off = $urandom_range(16'hFFF0, 16'hFFFF);
        else off = $urandom_range(0, 16'hFFFF);
        send_access(op, ADDR_W'(win_base + off), 2'($urandom_range(0, 3)), data);
      end else if (pick < 90) begin
        addr = $urandom_range(0, 1) ?
               ADDR_W'(win_base + WINDOW_SPAN + $urandom_range(0, 3)) :
               ADDR_W'(win_base - $urandom_range(1, 4));
        send_access(op, addr, 2'($urandom_range(0, 3)), data);
      end else begin
        send_access(2'($urandom_range(0, 3)), ADDR_W'($urandom), 2'($urandom_range(0, 3)),
                    data);
      end
    end
    steady_requests = 1'b0;
    steady_replies = 1'b0;
  endtask

  task automatic test_reply_stall();
    // The reply side holds off while transfers keep coming, filling the queue.
    hold_replies = 1'b1;
    steady_requests = 1'b1;
    for (int n = 0; n < 16; n++) begin
      if (n % 2 == 0)
        send_access(OP_MEM_WR, ADDR_W'(win_base + $urandom_range(0, 63)), SZ_DWORD, $urandom);
      else
        send_access(OP_IO_RD, REG_PORT_BASE + ADDR_W'($urandom_range(0, REG_NUM - 1)),
                    SZ_BYTE, 32'h0);
    end
    steady_requests = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.operation = OP_IO_RD;
    req_bus.address = '0;
    req_bus.access_size = SZ_BYTE;
    req_bus.write_data = '0;
    for (int i = 0; i < REG_NUM; i++) reg_bank[i] = 8'h00;
    reg_bank[REG_MODE] = 8'h01;
    reg_bank[REG_APERTURE] = 8'h01;
    win_base = WINDOW_RESET;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_id_ports();
    test_register_bank();
    test_mode_gate();
    test_aperture_control();
    test_memory_sizes();
    test_window_edges();
    test_memory_limit();
    test_random_traffic();
    test_reply_stall();

    req_bus.valid = 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("graphics_aperture_register_window: match");
    end else begin
      $display("graphics_aperture_register_window: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/gar_pkg.sv
sv/gar_req_if.sv
sv/gar_rsp_if.sv
sv/gar_ram.sv
sv/gar_front.sv
sv/gar_queue.sv
sv/gar_back.sv
sv/graphics_aperture_register_window.sv
sv/gar_checker.sv
sim/tb_graphics_aperture_register_window.sv
